FILE: sv/csalu_pkg.sv
// Shared types and constants for the checked signed ALU.
package csalu_pkg;

  localparam int NCELL = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_NEG = 3'd5
  } csalu_op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEFT  = 2'd1;
  localparam logic [1:0] ST_RIGHT = 2'd2;
  localparam logic [1:0] ST_ARITH = 2'd3;

  typedef struct packed {
    csalu_op_t   op;
    logic        narrow;
    logic [1:0]  status;
    logic        neg;
    logic [63:0] res;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] m;
  } csalu_work_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [1:0]  status;
  } csalu_res_t;

endpackage

FILE: sv/csalu_if.sv
// Item channel interfaces for the checked signed ALU.
interface csalu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic               narrow_mode;
  logic signed [63:0] left_value;
  logic signed [63:0] right_value;
  logic               left_is_integer;
  logic               right_is_integer;
  modport source(output valid, req_type, narrow_mode, left_value, right_value,
                 left_is_integer, right_is_integer, input ready);
  modport sink(input valid, req_type, narrow_mode, left_value, right_value,
               left_is_integer, right_is_integer, output ready);
endinterface

interface csalu_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [1:0]         status;
  modport source(output valid, result_value, status, input ready);
  modport sink(input valid, result_value, status, output ready);
endinterface

FILE: sv/checked_signed_alu.sv
// Top level of the checked signed ALU: front stage, 64-cell chain, output stage.
// An accepted item passes the front register, the 64 cell registers and the output register.
// One item per cycle unless stalled; each cell resolves one multiply or quotient bit.
// Stages advance independently, so bubbles close up while the output is stalled.
// Reset: synchronous active-low rst_n clears all stage valid bits; in_ch.ready is low.
module checked_signed_alu import csalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  csalu_in_if.sink    in_ch,
  csalu_out_if.source out_ch
);
  logic        v   [0:NCELL+1];
  logic        rdy [0:NCELL+2];
  csalu_work_t stg [0:NCELL];
  csalu_res_t  res;

  assign rdy[NCELL+2] = out_ch.ready;
  always_comb begin
    for (int k = 0; k <= NCELL + 1; k++) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ch.ready = rdy[0] && rst_n;

  csalu_front u_front (
    .clk, .rst_n, .en(rdy[0]), .valid_in(in_ch.valid && rst_n),
    .req_type(in_ch.req_type), .narrow_mode(in_ch.narrow_mode),
    .left_value(in_ch.left_value), .right_value(in_ch.right_value),
    .left_is_integer(in_ch.left_is_integer), .right_is_integer(in_ch.right_is_integer),
    .valid_r(v[0]), .work_r(stg[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    csalu_cell u_cell (
      .clk, .rst_n, .en(rdy[i+1]), .valid_in(v[i]), .work_in(stg[i]),
      .valid_r(v[i+1]), .work_r(stg[i+1])
    );
  end

  csalu_back u_back (
    .clk, .rst_n, .en(rdy[NCELL+1]), .valid_in(v[NCELL]), .work_in(stg[NCELL]),
    .valid_r(v[NCELL+1]), .res_r(res)
  );

  assign out_ch.valid        = v[NCELL+1];
  assign out_ch.result_value = res.result_value;
  assign out_ch.status       = res.status;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.result_value == 64'd0)
    else $error("nonzero result with error status");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v[NCELL] && !rdy[NCELL+1] |=> v[NCELL])
    else $error("last cell lost an item under stall");
endmodule

FILE: sv/csalu_front.sv
// Operand decode, type checks and the add, subtract, compare and negate operations.
module csalu_front import csalu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_in,
  input  logic [2:0]         req_type,
  input  logic               narrow_mode,
  input  logic [63:0]        left_value,
  input  logic [63:0]        right_value,
  input  logic               left_is_integer,
  input  logic               right_is_integer,
  output logic               valid_r,
  output csalu_work_t        work_r
);
  logic [63:0] a, b, sum, dif, mag_a, mag_b, minv;
  logic        add_ov, sub_ov, div_err, err;
  csalu_op_t   op;
  csalu_work_t work_nxt;

  always_comb begin
    op    = csalu_op_t'(req_type);
    a     = narrow_mode ? {{32{left_value[31]}}, left_value[31:0]} : left_value;
    b     = narrow_mode ? {{32{right_value[31]}}, right_value[31:0]} : right_value;
    sum   = a + b;
    dif   = a - b;
    add_ov = (a[63] == b[63]) && (sum[63] != a[63]);
    sub_ov = (a[63] != b[63]) && (dif[63] != a[63]);
    mag_a = a[63] ? (64'd0 - a) : a;
    mag_b = b[63] ? (64'd0 - b) : b;
    minv  = narrow_mode ? 64'hFFFF_FFFF_8000_0000 : 64'h8000_0000_0000_0000;
    div_err = (b == 64'd0) || ((a == minv) && (b == '1));
    work_nxt        = '0;
    work_nxt.op     = op;
    work_nxt.narrow = narrow_mode;
    work_nxt.neg    = a[63] ^ b[63];
    work_nxt.hi     = '0;
    work_nxt.lo     = mag_a;
    work_nxt.m      = mag_b;
    err             = 1'b0;
    case (op)
      OP_ADD: begin
        work_nxt.res = sum;
        err = add_ov;
      end
      OP_SUB: begin
        work_nxt.res = dif;
        err = sub_ov;
      end
      OP_MUL: work_nxt.res = '0;
      OP_DIV: err = div_err;
      OP_CMP: begin
        if ($signed(a) < $signed(b)) work_nxt.res = '1;
        else if (a == b) work_nxt.res = 64'd0;
        else work_nxt.res = 64'd1;
      end
      OP_NEG: work_nxt.res = 64'd0 - a;
      default: err = 1'b1;
    endcase
    if (!left_is_integer) work_nxt.status = ST_LEFT;
    else if (op != OP_NEG && !right_is_integer) work_nxt.status = ST_RIGHT;
    else if (err) work_nxt.status = ST_ARITH;
    else work_nxt.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      work_r <= work_nxt;
    end
  end
endmodule

FILE: sv/csalu_cell.sv
// One shift-add multiply or restoring divide step per cell.
module csalu_cell import csalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        valid_in,
  input  csalu_work_t work_in,
  output logic        valid_r,
  output csalu_work_t work_r
);
  logic [64:0] s, t, tt;
  logic        ge;
  csalu_work_t work_nxt;

  always_comb begin
    work_nxt = work_in;
    s  = {1'b0, work_in.hi} + (work_in.lo[0] ? {1'b0, work_in.m} : 65'd0);
    t  = {work_in.hi, work_in.lo[63]};
    ge = t >= {1'b0, work_in.m};
    tt = ge ? (t - {1'b0, work_in.m}) : t;
    if (work_in.op == OP_MUL) begin
      work_nxt.hi = s[64:1];
      work_nxt.lo = {s[0], work_in.lo[63:1]};
    end else begin
      work_nxt.hi = tt[63:0];
      work_nxt.lo = {work_in.lo[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      work_r <= work_nxt;
    end
  end
endmodule

FILE: sv/csalu_back.sv
// Range checks, sign fix-up and the output register.
module csalu_back import csalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        valid_in,
  input  csalu_work_t work_in,
  output logic        valid_r,
  output csalu_res_t  res_r
);
  logic [63:0] lim, r;
  logic        err;
  csalu_res_t  res_nxt;

  always_comb begin
    lim = work_in.narrow ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
    if (!work_in.neg) lim = lim - 64'd1;
    err = 1'b0;
    case (work_in.op)
      OP_MUL: begin
        err = (work_in.hi != 64'd0) || (work_in.lo > lim);
        r = work_in.neg ? (64'd0 - work_in.lo) : work_in.lo;
      end
      OP_DIV: r = work_in.neg ? (64'd0 - work_in.lo) : work_in.lo;
      default: r = work_in.res;
    endcase
    if (work_in.narrow && work_in.op != OP_NEG && !((&r[63:31]) || !(|r[63:31])))
      err = 1'b1;
    if (work_in.narrow) r = {{32{r[31]}}, r[31:0]};
    if (work_in.status != ST_OK) begin
      res_nxt.status = work_in.status;
      res_nxt.result_value = '0;
    end else if (err) begin
      res_nxt.status = ST_ARITH;
      res_nxt.result_value = '0;
    end else begin
      res_nxt.status = ST_OK;
      res_nxt.result_value = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      res_r <= res_nxt;
    end
  end
endmodule

FILE: sim/checked_signed_alu_test.sv
// Testbench for the checked signed ALU: random and directed items checked against a predictor.
`timescale 1ns / 100ps
module checked_signed_alu_test;
  import csalu_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic        narrow;
    logic [63:0] a;
    logic [63:0] b;
    logic        a_int;
    logic        b_int;
  } alu_req_t;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN32 = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MAX32 = 64'h0000_0000_7FFF_FFFF;
  localparam int          WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  csalu_in_if  in_ch();
  csalu_out_if out_ch();

  checked_signed_alu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  alu_req_t   pending_q[$];
  csalu_res_t expected_q[$];
  int         mismatches = 0;
  int         accepted_in = 0;
  int         idle_cycles = 0;
  bit         stim_done = 1'b0;
  bit         src_quiet = 1'b0;
  bit         src_steady = 1'b0;
  bit         snk_steady = 1'b0;
  int         snk_hold = 0;

  function automatic logic [63:0] sext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic csalu_res_t alu_predict(alu_req_t q);
    csalu_res_t      res;
    logic [63:0]     a, b, r, minv;
    logic signed [63:0] sa, sb;
    logic signed [127:0] prod;
    logic signed [64:0] wide;
    bit              err;
    a = q.a;
    b = q.b;
    r = '0;
    err = 1'b0;
    minv = q.narrow ? MIN32 : MIN64;
    if (q.narrow) begin
      a = sext32(a);
      b = sext32(b);
    end
    sa = a;
    sb = b;
    if (!q.a_int) begin
      res.status = ST_LEFT;
    end else if (q.op != OP_NEG && !q.b_int) begin
      res.status = ST_RIGHT;
    end else begin
      case (q.op)
        OP_ADD: begin
          wide = {sa[63], sa} + {sb[63], sb};
          r = wide[63:0];
          err = wide[64] != wide[63];
        end
        OP_SUB: begin
          wide = {sa[63], sa} - {sb[63], sb};
          r = wide[63:0];
          err = wide[64] != wide[63];
        end
        OP_MUL: begin
          prod = 128'(sa) * 128'(sb);
          r = prod[63:0];
          err = prod != 128'(signed'(r));
        end
        OP_DIV: begin
          if (b == 0 || (a == minv && b == ONES)) err = 1'b1;
          else if (a == MIN64 && b == ONES) err = 1'b1;
          else r = sa / sb;
        end
        OP_CMP: r = (sa < sb) ? ONES : (sa == sb ? 64'd0 : 64'd1);
        OP_NEG: r = -a;
        default: err = 1'b1;
      endcase
      if (!err && q.narrow && q.op != OP_NEG && sext32(r) != r) err = 1'b1;
      if (q.narrow) r = sext32(r);
      res.status = err ? ST_ARITH : ST_OK;
    end
    res.result_value = (res.status == ST_OK) ? r : 64'd0;
    return res;
  endfunction

  function automatic logic [63:0] pick_value(logic narrow);
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = MIN64;
      1: v = MAX64;
      2: v = ONES;
      3: v = 64'd0;
      4: v = 64'(signed'($urandom_range(0, 20)) - 10);
      5: v = narrow ? {$urandom, 32'h8000_0000} : MIN32;
      6: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      7: v = narrow ? {$urandom, 32'h7FFF_FFFF} : MAX32;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic push_req(logic [2:0] op, logic narrow, logic [63:0] a, logic [63:0] b,
                          logic a_int, logic b_int);
    alu_req_t q;
    q.op = op;
    q.narrow = narrow;
    q.a = a;
    q.b = b;
    q.a_int = a_int;
    q.b_int = b_int;
    pending_q.push_back(q);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.narrow_mode = 1'b0;
    in_ch.left_value = '0;
    in_ch.right_value = '0;
    in_ch.left_is_integer = 1'b0;
    in_ch.right_is_integer = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_req(OP_ADD, 0, MAX64, 64'd1, 1, 1);
    push_req(OP_ADD, 0, MIN64, ONES, 1, 1);
    push_req(OP_SUB, 0, MIN64, 64'd1, 1, 1);
    push_req(OP_SUB, 1, MAX32, ONES, 1, 1);
    push_req(OP_MUL, 0, MIN64, ONES, 1, 1);
    push_req(OP_MUL, 0, MIN64, 64'd1, 1, 1);
    push_req(OP_MUL, 1, 64'h1_0001_0000, 64'h1_0000, 1, 1);
    push_req(OP_MUL, 1, MIN32, 64'd1, 1, 1);
    push_req(OP_DIV, 0, MIN64, ONES, 1, 1);
    push_req(OP_DIV, 1, MIN32, ONES, 1, 1);
    push_req(OP_DIV, 0, 64'd7, 64'd0, 1, 1);
    push_req(OP_DIV, 0, -64'sd7, 64'd2, 1, 1);
    push_req(OP_CMP, 0, MIN64, MAX64, 1, 1);
    push_req(OP_CMP, 0, MAX64, MIN64, 1, 1);
    push_req(OP_CMP, 1, 64'hABCD_0000_0005, 64'd5, 1, 1);
    push_req(OP_NEG, 0, MIN64, 64'd0, 1, 0);
    push_req(OP_NEG, 1, MIN32, ONES, 1, 0);
    push_req(OP_ADD, 0, 64'd1, 64'd1, 0, 0);
    push_req(OP_SUB, 0, 64'd1, 64'd1, 1, 0);
    push_req(3'd6, 0, 64'd1, 64'd1, 1, 1);
    push_req(3'd7, 1, 64'd1, 64'd1, 1, 1);
    push_req(3'd7, 1, 64'd1, 64'd1, 1, 0);

    for (int i = 0; i < 1750; i++) begin
      logic nr;
      nr = $urandom_range(0, 1);
      push_req($urandom_range(0, 99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5)),
               nr, pick_value(nr), pick_value(nr),
               $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
      if (i == 600) begin
        wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
        src_quiet = 1'b1;
        repeat (20) @(posedge clk);
        src_quiet = 1'b0;
      end
    end
    wait (pending_q.size() == 0 && !in_ch.valid);
    wait (expected_q.size() == 0);
    repeat (80) @(posedge clk);
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        alu_req_t q;
        q.op = in_ch.req_type;
        q.narrow = in_ch.narrow_mode;
        q.a = in_ch.left_value;
        q.b = in_ch.right_value;
        q.a_int = in_ch.left_is_integer;
        q.b_int = in_ch.right_is_integer;
        expected_q.push_back(alu_predict(q));
        accepted_in++;
      end
      src_steady <= accepted_in >= 200 && accepted_in < 500;
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending_q.size() != 0 && !src_quiet && (src_steady || $urandom_range(0, 99) >= 33))
        begin
          alu_req_t q;
          q = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= q.op;
          in_ch.narrow_mode <= q.narrow;
          in_ch.left_value <= q.a;
          in_ch.right_value <= q.b;
          in_ch.left_is_integer <= q.a_int;
          in_ch.right_is_integer <= q.b_int;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        csalu_res_t exp_r;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h status %0d",
                                         out_ch.result_value, out_ch.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.result_value !== out_ch.result_value || exp_r.status !== out_ch.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h status %0d, got %h status %0d",
                       exp_r.result_value, exp_r.status, out_ch.result_value, out_ch.status);
          end
        end
      end
      snk_steady <= accepted_in >= 900 && accepted_in < 1200;
      if (accepted_in == 300 && snk_hold == 0) snk_hold = 400;
      if (snk_hold > 1) begin
        snk_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= snk_steady || $urandom_range(0, 99) >= 33;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n || src_quiet
        || snk_hold > 1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (stim_done) begin
      if (mismatches == 0 && expected_q.size() == 0)
        $display("checked_signed_alu_test OK");
      else
        $display("checked_signed_alu_test NOT OK");
      $finish;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("checked_signed_alu_test NOT OK");
      $finish;
    end
  end

endmodule

FILE: sim.f
sv/csalu_pkg.sv
sv/csalu_if.sv
sv/csalu_front.sv
sv/csalu_cell.sv
sv/csalu_back.sv
sv/checked_signed_alu.sv
sim/checked_signed_alu_test.sv
